### src/note_consensus_vote_filter_defines.svh
// Assertion macros shared by the vote filter modules.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef NOTE_CONSENSUS_VOTE_FILTER_DEFINES_SVH
`define NOTE_CONSENSUS_VOTE_FILTER_DEFINES_SVH

// Same-cycle implication checked at every clock edge outside reset.
`define NCVF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked at every clock edge outside reset.
`define NCVF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ncvf_pkg.sv
// Package for the note vote filter: sizes, field widths, command struct and a saturating count helper.
// Used by the controller, the datapath and the top level; depends on nothing.
package ncvf_pkg;

  localparam int WINDOW       = 5;
  localparam int NOTE_CLASSES = 12;

  localparam int CLASS_W = 4;
  localparam int REQ_W   = 3;
  localparam int OCNT_W  = 3;
  localparam logic [REQ_W-1:0] REQ_RESET = 3'd4;

  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int IDX_W  = $clog2(NOTE_CLASSES);

  localparam int IN_W     = CLASS_W;
  localparam int IN_TW    = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W    = CLASS_W + 2 * OCNT_W;
  localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic             accept;
    logic             scan;
    logic [IDX_W-1:0] idx;
    logic             load;
  } ncvf_cmd_t;

  function automatic logic [OCNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
    if (int'(v) > 7) begin
      return 3'd7;
    end
    return OCNT_W'(v);
  endfunction

endpackage

### src/ncvf_ctrl.sv
// Controller of the note vote filter: window fill count, class scan and result load.
// Depends on ncvf_pkg and the assertion macro header.
`include "note_consensus_vote_filter_defines.svh"

module ncvf_ctrl
  import ncvf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_free,
  output ncvf_cmd_t cmd
);

  typedef enum logic [1:0] {ST_COLLECT, ST_SCAN, ST_LOAD} state_t;

  state_t            state;
  logic [FILL_W-1:0] fill;
  logic [IDX_W-1:0]  idx;

  assign in_ready   = (state == ST_COLLECT);
  assign cmd.accept = in_valid && in_ready;
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.idx    = idx;
  assign cmd.load   = (state == ST_LOAD) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      fill  <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        ST_COLLECT: begin
          if (cmd.accept) begin
            if (fill == FILL_W'(WINDOW - 1)) begin
              fill  <= '0;
              idx   <= '0;
              state <= ST_SCAN;
            end else begin
              fill <= fill + 1'b1;
            end
          end
        end
        ST_SCAN: begin
          idx <= idx + 1'b1;
          if (idx == IDX_W'(NOTE_CLASSES - 1)) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (out_free) begin
            state <= ST_COLLECT;
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

  `NCVF_ASSERT_NOW(a_fill_range, 1'b1, int'(fill) < WINDOW, "fill count beyond window")
  `NCVF_ASSERT_NEXT(a_last_item_scans, cmd.accept && (fill == FILL_W'(WINDOW - 1)),
    state == ST_SCAN && idx == '0, "window end did not start the scan")
  `NCVF_ASSERT_NEXT(a_load_returns, cmd.load, state == ST_COLLECT && fill == '0,
    "result load did not reopen the window")

endmodule

### src/ncvf_dpath.sv
// Datapath of the note vote filter: class histogram, top and median scan, output register.
// Depends on ncvf_pkg and the assertion macro header; driven by ncvf_ctrl commands.
`include "note_consensus_vote_filter_defines.svh"

module ncvf_dpath
  import ncvf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ncvf_cmd_t          cmd,
  input  logic               in_note_valid,
  input  logic [CLASS_W-1:0] in_note_class,
  input  logic               cfg_we,
  input  logic [REQ_W-1:0]   cfg_req,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_decision_valid,
  output logic [CLASS_W-1:0] out_decision_note,
  output logic [OCNT_W-1:0]  out_top_count,
  output logic [OCNT_W-1:0]  out_valid_count
);

  logic [CNT_W-1:0] hist [NOTE_CLASSES];
  logic [CNT_W-1:0] valid_cnt;
  logic [CNT_W-1:0] top;
  logic [IDX_W-1:0] top_note;
  logic [CNT_W-1:0] cum;
  logic [IDX_W-1:0] median;
  logic             have_med;
  logic [REQ_W-1:0] required_count;

  logic             in_counted;
  logic [CNT_W-1:0] h_sel;
  logic [CNT_W-1:0] cum_next;
  logic [CNT_W-1:0] half;
  logic             stable;

  assign in_counted = in_note_valid &&
                      ({1'b0, in_note_class} < (CLASS_W + 1)'(NOTE_CLASSES));
  assign h_sel      = hist[cmd.idx];
  assign cum_next   = cum + h_sel;
  assign half       = valid_cnt >> 1;
  assign stable     = (valid_cnt != '0) && (int'(top) >= int'(required_count)) &&
                      have_med && (median == top_note);
  assign out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      required_count <= REQ_RESET;
    end else if (cfg_we) begin
      required_count <= cfg_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      for (int k = 0; k < NOTE_CLASSES; k++) begin
        hist[k] <= '0;
      end
      valid_cnt <= '0;
    end else if (cmd.accept && in_counted) begin
      for (int k = 0; k < NOTE_CLASSES; k++) begin
        if (in_note_class == CLASS_W'(k)) begin
          hist[k] <= hist[k] + 1'b1;
        end
      end
      valid_cnt <= valid_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      top      <= '0;
      top_note <= '0;
      cum      <= '0;
      median   <= '0;
      have_med <= 1'b0;
    end else if (cmd.scan) begin
      if (h_sel > top) begin
        top      <= h_sel;
        top_note <= cmd.idx;
      end
      cum <= cum_next;
      if (!have_med && (cum_next > half)) begin
        median   <= cmd.idx;
        have_med <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_decision_valid <= stable;
      out_decision_note  <= stable ? CLASS_W'(top_note) : '0;
      out_top_count      <= sat_cnt(top);
      out_valid_count    <= sat_cnt(valid_cnt);
    end
  end

  `NCVF_ASSERT_NOW(a_load_when_free, cmd.load, !out_valid || out_ready,
    "result overwritten before transfer")
  `NCVF_ASSERT_NOW(a_top_bounded, 1'b1, top <= valid_cnt && int'(valid_cnt) <= WINDOW,
    "top count exceeds valid count")
  `NCVF_ASSERT_NOW(a_no_mix, cmd.scan, !cmd.accept, "input accepted during scan")

endmodule

### src/note_consensus_vote_filter.sv
// Top level of the note vote filter: stream ports, controller and datapath.
// Depends on ncvf_pkg, ncvf_ctrl and ncvf_dpath.
//
// Each input transfer carries one note detection: s_tuser[0] is the detect flag and
// s_tdata[3:0] the note class. Five transfers form a window; the fifth one closes it
// and yields one result transfer, the other four yield none. Classes of 12 and above
// count as no note. The result gives the decision flag on m_tuser[0] and the note,
// top count and valid count on m_tdata.
// A window runs as five input transfers, then a scan that walks the class
// histogram one class per cycle over all 12 classes, then the result load.
// m_tvalid is raised by the result load. s_tready is low during the scan and the
// load. If the receiver stalls, the result is held on m_tdata and the next window
// still fills; its result waits in the load step until the earlier one is taken.
// The required count register is written through cfg_valid/cfg_data (cfg_ready is
// always high); the user must write it only while the block is idle, not enforced.
// Synchronous reset empties the window, drops any pending result and sets the
// required count to 4.
module note_consensus_vote_filter
  import ncvf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_TW-1:0]  s_tdata,   // note_class, zero padding
  input  logic [0:0]        s_tuser,   // note_valid
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_TW-1:0] m_tdata,   // decision_note, top_count, valid_count, padding
  output logic [0:0]        m_tuser,   // decision_valid
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [REQ_W-1:0]  cfg_data
);

  ncvf_cmd_t          cmd;
  logic               out_free;
  logic               dec_valid;
  logic [CLASS_W-1:0] dec_note;
  logic [OCNT_W-1:0]  top_count;
  logic [OCNT_W-1:0]  valid_count;

  assign cfg_ready = 1'b1;

  ncvf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .cmd      (cmd)
  );

  ncvf_dpath u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .in_note_valid      (s_tuser[0]),
    .in_note_class      (s_tdata[CLASS_W-1:0]),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_req            (cfg_data),
    .out_free           (out_free),
    .out_valid          (m_tvalid),
    .out_ready          (m_tready),
    .out_decision_valid (dec_valid),
    .out_decision_note  (dec_note),
    .out_top_count      (top_count),
    .out_valid_count    (valid_count)
  );

  assign m_tuser = dec_valid;
  assign m_tdata = OUT_TW'({valid_count, top_count, dec_note});

endmodule
